@@ hw/rtl/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 validating decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ByteCont     = 8'h80;
  localparam logic [7:0] ByteContLast = 8'hBF;
  localparam logic [7:0] ByteLeadMin  = 8'hC2;
  localparam logic [7:0] ByteLead2Max = 8'hDF;
  localparam logic [7:0] ByteLead3Min = 8'hE0;
  localparam logic [7:0] ByteLead3Max = 8'hEF;
  localparam logic [7:0] ByteLead4Min = 8'hF0;
  localparam logic [7:0] ByteLeadMax  = 8'hF4;

  localparam logic [CpW-1:0] SurrLo = CpW'(32'hD800);
  localparam logic [CpW-1:0] SurrHi = CpW'(32'hDFFF);
  // first value that no longer fits a two- or three-byte sequence
  localparam logic [CpW-1:0] Lim2   = CpW'(32'd1 << (5 + 6));
  localparam logic [CpW-1:0] Lim3   = CpW'(32'd1 << (4 + 6 + 6));
  localparam logic [CpW-1:0] CpMax  = CpW'(32'h13FFFF);

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } utf8d_cls_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
    logic       start;
    utf8d_cls_e cls;
  } utf8d_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } utf8d_qstat_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           err;
  } utf8d_res_t;

endpackage

@@ hw/rtl/utf8d_front.sv @@
// ----------------------------------------------------------------------------
// utf8d_front
// Input stage: accepts a byte, classifies it and registers the word.
// ----------------------------------------------------------------------------
module utf8d_front import utf8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_buffer_i,
  input  logic        q_full_i,
  output logic        push_valid_o,
  output utf8d_word_t push_word_o
);

  logic        valid_q, valid_d;
  utf8d_word_t word_q;
  utf8d_word_t word_d;
  utf8d_cls_e  cls;

  always_comb begin
    case (in_byte_i) inside
      [8'h00:8'h7F]:                 cls = CLS_ASCII;
      [ByteCont:ByteContLast]:       cls = CLS_CONT;
      [ByteLeadMin:ByteLead2Max]:    cls = CLS_LEAD2;
      [ByteLead3Min:ByteLead3Max]:   cls = CLS_LEAD3;
      [ByteLead4Min:ByteLeadMax]:    cls = CLS_LEAD4;
      default:                       cls = CLS_BAD;
    endcase
  end

  always_comb begin
    word_d.data  = in_byte_i;
    word_d.eob   = end_of_buffer_i;
    word_d.cls   = cls;
    // 0x80 ends a skip run even though it is no valid lead
    word_d.start = (cls != CLS_CONT && cls != CLS_BAD) || (in_byte_i == ByteCont);
  end

  // hold the word while the queue is full
  assign in_stall_o = valid_q && q_full_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      word_q <= word_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_word_o  = word_q;

endmodule

@@ hw/rtl/utf8d_queue.sv @@
// ----------------------------------------------------------------------------
// utf8d_queue
// Short FIFO of classified words between the front and back parts.
// ----------------------------------------------------------------------------
module utf8d_queue import utf8d_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  input  utf8d_word_t  push_word_i,
  input  logic         pop_i,
  output utf8d_word_t  word_o,
  output utf8d_qstat_t stat_o
);

  utf8d_word_t      mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign push = push_valid_i && !stat_o.full;
  assign pop  = pop_i && !stat_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  assign word_o = mem_q[rd_ptr_q];

endmodule

@@ hw/rtl/utf8d_back.sv @@
// ----------------------------------------------------------------------------
// utf8d_back
// Decode stage: keeps sequence state, builds results, drives the output.
// ----------------------------------------------------------------------------
module utf8d_back import utf8d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             word_valid_i,
  input  utf8d_word_t      word_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CpW-1:0]   code_point_o,
  output logic             is_error_o,
  output logic             last_of_run_o
);

  typedef struct packed {
    logic           emit;
    utf8d_res_t     res;
    logic [1:0]     bl;
    logic [2:0]     len;
    logic [CpW-1:0] pv;
    logic           skip_set;
  } utf8d_sc_t;

  function automatic utf8d_sc_t start_char(utf8d_word_t w);
    utf8d_sc_t s;
    s = '0;
    case (w.cls)
      CLS_ASCII: begin
        s.emit   = 1'b1;
        s.res.cp = CpW'(w.data);
      end
      CLS_LEAD2: begin
        s.pv  = CpW'(w.data & 8'h1F);
        s.len = 3'd2;
        s.bl  = 2'd1;
      end
      CLS_LEAD3: begin
        s.pv  = CpW'(w.data & 8'h0F);
        s.len = 3'd3;
        s.bl  = 2'd2;
      end
      CLS_LEAD4: begin
        s.pv  = CpW'(w.data & 8'h07);
        s.len = 3'd4;
        s.bl  = 2'd3;
      end
      default: begin
        s.emit     = 1'b1;
        s.res.err  = 1'b1;
        s.skip_set = 1'b1;
      end
    endcase
    // a lead byte at the end of the buffer is a truncated sequence
    if (w.eob && (w.cls == CLS_LEAD2 || w.cls == CLS_LEAD3 || w.cls == CLS_LEAD4)) begin
      s.emit    = 1'b1;
      s.res.err = 1'b1;
    end
    return s;
  endfunction

  function automatic utf8d_res_t finish(logic [CpW-1:0] v, logic [2:0] len);
    utf8d_res_t r;
    logic [2:0] need;
    if (v < Lim2) begin
      need = 3'd2;
    end else if (v < Lim3) begin
      need = 3'd3;
    end else begin
      need = 3'd4;
    end
    r.err = (v >= SurrLo && v <= SurrHi) || (len != need);
    r.cp  = r.err ? '0 : v;
    return r;
  endfunction

  logic [1:0]     bl_q, bl_d;
  logic [2:0]     len_q, len_d;
  logic [CpW-1:0] pv_q, pv_d;
  logic           skip_q, skip_d;
  logic           phase_q, phase_d;
  logic           out_valid_q, out_valid_d;
  utf8d_res_t     out_res_q;
  logic           out_last_q;

  utf8d_sc_t      sc;
  utf8d_res_t     res0, res1;
  logic [1:0]     cnt;
  logic [CpW-1:0] pv_ext;
  logic           load_ok;

  // one byte step: results and the state it leaves
  always_comb begin
    sc     = start_char(word_i);
    res0   = '0;
    res1   = '0;
    cnt    = 2'd0;
    bl_d   = bl_q;
    len_d  = len_q;
    pv_d   = pv_q;
    skip_d = skip_q;
    pv_ext = {pv_q[CpW-7:0], word_i.data[5:0]};
    if (bl_q != 2'd0) begin
      if (word_i.cls == CLS_CONT) begin
        bl_d = bl_q - 2'd1;
        pv_d = pv_ext;
        if (bl_d == 2'd0) begin
          cnt   = 2'd1;
          res0  = finish(pv_ext, len_q);
          len_d = '0;
          pv_d  = '0;
        end else if (word_i.eob) begin
          cnt      = 2'd1;
          res0.err = 1'b1;
        end
      end else begin
        // bad continuation: flag it, then retry the byte as a lead
        res0.err = 1'b1;
        cnt      = {1'b0, sc.emit} + 2'd1;
        res1     = sc.res;
        bl_d     = sc.bl;
        len_d    = sc.len;
        pv_d     = sc.pv;
        skip_d   = skip_q | sc.skip_set;
      end
    end else if (!(skip_q && !word_i.start)) begin
      cnt    = {1'b0, sc.emit};
      res0   = sc.res;
      bl_d   = sc.bl;
      len_d  = sc.len;
      pv_d   = sc.pv;
      skip_d = sc.skip_set;
    end
    if (word_i.eob) begin
      bl_d   = '0;
      len_d  = '0;
      pv_d   = '0;
      skip_d = 1'b0;
    end
  end

  assign load_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    pop_o       = word_valid_i && ((cnt == 2'd0) ||
                  (load_ok && ((cnt == 2'd1) || phase_q)));
    out_valid_d = load_ok ? (word_valid_i && cnt != 2'd0) : out_valid_q;
    phase_d     = phase_q;
    if (pop_o) begin
      phase_d = 1'b0;
    end else if (word_valid_i && load_ok && cnt == 2'd2) begin
      phase_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_q        <= '0;
      len_q       <= '0;
      pv_q        <= '0;
      skip_q      <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // advance the sequence state only when the word leaves the queue
      if (pop_o) begin
        bl_q   <= bl_d;
        len_q  <= len_d;
        pv_q   <= pv_d;
        skip_q <= skip_d;
      end
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok && word_valid_i && cnt != 2'd0) begin
      out_res_q  <= phase_q ? res1 : res0;
      out_last_q <= (cnt == 2'd1) || phase_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = out_res_q.cp;
  assign is_error_o    = out_res_q.err;
  assign last_of_run_o = out_last_q;

endmodule

@@ hw/rtl/utf8_validating_decoder_top.sv @@
// ----------------------------------------------------------------------------
// utf8_validating_decoder_top
// UTF-8 validating decoder: bytes in, code points or error marks out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_stall_o is low and returns zero, one
// or two results per byte, each with code_point_o, is_error_o and
// last_of_run_o (set on the last result of a byte). A byte passes an input
// register, a four-word queue and the decode stage with its output register.
// The decode stage emits one result per cycle while out_stall_i is low: a
// byte that gives two results (a bad continuation followed by another
// result) stays at the head of the queue until both have been loaded. The
// queue absorbs these waits and short output stalls, so input keeps flowing
// at one byte per cycle while it has room.
module utf8_validating_decoder_top import utf8d_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     in_byte_i,
  input  logic           end_of_buffer_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [CpW-1:0] code_point_o,
  output logic           is_error_o,
  output logic           last_of_run_o
);

  logic         push_valid;
  utf8d_word_t  push_word;
  utf8d_word_t  q_word;
  utf8d_qstat_t q_stat;
  logic         pop;

  utf8d_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .q_full_i        (q_stat.full),
    .push_valid_o    (push_valid),
    .push_word_o     (push_word)
  );

  utf8d_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_word_i  (push_word),
    .pop_i        (pop),
    .word_o       (q_word),
    .stat_o       (q_stat)
  );

  utf8d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .word_valid_i  (!q_stat.empty),
    .word_i        (q_word),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .is_error_o    (is_error_o),
    .last_of_run_o (last_of_run_o)
  );

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_error_o |-> code_point_o == '0)
    else $error("error result carries a nonzero code point");

  a_cp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_error_o |-> code_point_o <= CpMax)
    else $error("code point above decoder range");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o && !out_stall_i |=> out_valid_o)
    else $error("second result of a byte did not follow at once");

  a_queue_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("decode stage pops an empty queue");
`endif

endmodule
